// ===== hw/rtl/calibration_record_checker_defines.svh =====
// Assertion macros shared by the calibration record checker verification files.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef CALIBRATION_RECORD_CHECKER_DEFINES_SVH
`define CALIBRATION_RECORD_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CALREC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calibration_record_checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CALREC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calibration_record_checker: next-cycle check failed");

`endif

// ===== hw/rtl/calrec_pkg.sv =====
// Types, constants and the CRC-32 word update for the calibration record checker.
// No dependencies; imported by calrec_eval, calibration_record_checker and calrec_checker.
`default_nettype none

package calrec_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 152;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HELD_DEPTH = 6;
  localparam int CNT_W      = 3;

  localparam logic [31:0] REC_MAGIC   = 32'h5946_4F43;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [15:0] VERSION_ONE = 16'd1;
  localparam logic [15:0] VERSION_TWO = 16'd2;
  localparam logic [15:0] DIR_POS     = 16'h0001;
  localparam logic [15:0] DIR_NEG     = 16'hFFFF;

  localparam logic [CNT_W-1:0] FIRST_IDX = 3'd0;
  localparam logic [CNT_W-1:0] LAST_IDX  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_PP_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PP_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NID_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NID_MAX = 2'd3;

  typedef struct packed {
    logic [15:0] pp_min;
    logic [15:0] pp_max;
    logic [7:0]  nid_min;
    logic [7:0]  nid_max;
  } calrec_cfg_t;

  // words 1..6 of the record
  typedef logic [HELD_DEPTH-1:0][31:0] calrec_held_t;

  typedef struct packed {
    logic              record_ok;
    logic [7:0]        pair_count;
    logic signed [7:0] encoder_sense;
    logic signed [7:0] loop_sense;
    logic [31:0]       offset_bits;
    logic [7:0]        node_number;
    logic              gains_valid;
    logic [15:0]       velocity_kp;
    logic [15:0]       velocity_ki;
    logic [15:0]       position_kp;
    logic [15:0]       position_ki;
    logic [15:0]       position_kd;
  } calrec_result_t;

  // Reflected CRC-32 over one little-endian word; reduces to an XOR network.
  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] word);
    logic [31:0] c;
    c = crc ^ word;
    for (int b = 0; b < 32; b++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/calibration_record_checker.sv =====
// Top level of the calibration record checker: stream ports, record state, output skid.
// Depends on calrec_pkg and calrec_eval.
//
// Takes an eight-word calibration record one 32-bit word per cycle, runs a
// reflected CRC-32 over words 0..6 with a combinational XOR network per word,
// and, once word 7 is accepted and registered, presents one result word carrying the
// unpacked fields and, in out_tuser, the pass flag. in_tuser high marks word 0
// and restarts a record; a word arriving after word 7 is also taken as word 0.
// Throughput is one word per cycle; the input stalls only when both the output
// register and its skid register hold unread results. Configuration writes take
// effect at the next edge and must only happen while the block is idle.
`default_nettype none

module calibration_record_checker
  import calrec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] record_word
  input  logic                  in_tuser,   // [0] first_word

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] pair_count, [15:8] encoder_sense, [23:16] loop_sense,
  // [55:24] offset_bits, [63:56] node_number, [64] gains_valid,
  // [80:65] velocity_kp, [96:81] velocity_ki, [112:97] position_kp,
  // [128:113] position_ki, [144:129] position_kd, [151:145] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] record_ok

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  calrec_cfg_t      cfg_r, cfg_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             magic_r, magic_nxt;
  calrec_held_t     held_r;

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  calrec_result_t   out_res_r, out_res_nxt;
  calrec_result_t   skid_res_r, skid_res_nxt;

  logic             accept;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] hidx;
  logic             produce;
  logic [31:0]      crc_upd;
  calrec_result_t   res;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign idx       = in_tuser ? FIRST_IDX : cnt_r;
  assign hidx      = idx - 3'd1;
  assign produce   = accept && (idx == LAST_IDX);
  assign crc_upd   = crc32_word((idx == FIRST_IDX) ? CRC_INIT : crc_r, in_tdata);

  calrec_eval u_eval (
    .held        (held_r),
    .crc_word_in (in_tdata),
    .crc_acc     (crc_r),
    .magic_ok    (magic_r),
    .cfg         (cfg_r),
    .res         (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PP_MIN:  cfg_nxt.pp_min  = cfg_wdata;
        REG_PP_MAX:  cfg_nxt.pp_max  = cfg_wdata;
        REG_NID_MIN: cfg_nxt.nid_min = cfg_wdata[7:0];
        REG_NID_MAX: cfg_nxt.nid_max = cfg_wdata[7:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    magic_nxt = magic_r;
    if (accept) begin
      if (idx == FIRST_IDX) begin
        crc_nxt   = crc_upd;
        magic_nxt = (in_tdata == REC_MAGIC);
        cnt_nxt   = 3'd1;
      end else if (idx != LAST_IDX) begin
        crc_nxt = crc_upd;
        cnt_nxt = idx + 3'd1;
      end else begin
        crc_nxt   = CRC_INIT;
        magic_nxt = 1'b0;
        cnt_nxt   = FIRST_IDX;
      end
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || out_tready) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pp_min  <= 16'd1;
      cfg_r.pp_max  <= 16'd50;
      cfg_r.nid_min <= 8'd1;
      cfg_r.nid_max <= 8'd127;
      crc_r         <= CRC_INIT;
      cnt_r         <= FIRST_IDX;
      magic_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      crc_r        <= crc_nxt;
      cnt_r        <= cnt_nxt;
      magic_r      <= magic_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
    if (accept && (idx != FIRST_IDX) && (idx != LAST_IDX)) begin
      held_r[hidx] <= in_tdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.record_ok;
  assign out_tdata  = {7'd0,
                       out_res_r.position_kd,
                       out_res_r.position_ki,
                       out_res_r.position_kp,
                       out_res_r.velocity_ki,
                       out_res_r.velocity_kp,
                       out_res_r.gains_valid,
                       out_res_r.node_number,
                       out_res_r.offset_bits,
                       out_res_r.loop_sense,
                       out_res_r.encoder_sense,
                       out_res_r.pair_count};

endmodule

`default_nettype wire

// ===== hw/rtl/calrec_eval.sv =====
// Record evaluation: field unpacking, CRC compare, range and direction checks.
// Depends on calrec_pkg; instantiated by calibration_record_checker.
`default_nettype none

module calrec_eval
  import calrec_pkg::*;
(
  input  calrec_held_t   held,
  input  logic [31:0]    crc_word_in,
  input  logic [31:0]    crc_acc,
  input  logic           magic_ok,
  input  calrec_cfg_t    cfg,
  output calrec_result_t res
);

  logic [15:0] version;
  logic [15:0] pp;
  logic [15:0] enc_dir;
  logic [15:0] loop_dir;
  logic [7:0]  nid;
  logic        gains;
  logic        version_ok;
  logic        crc_ok;
  logic        pp_ok;
  logic        dir_ok;

  always_comb begin
    version    = held[0][15:0];
    pp         = held[0][31:16];
    enc_dir    = held[1][15:0];
    loop_dir   = held[1][31:16];
    nid        = held[3][7:0];
    gains      = (version >= VERSION_TWO);
    version_ok = (version == VERSION_ONE) || (version == VERSION_TWO);
    crc_ok     = (~crc_acc == crc_word_in);
    pp_ok      = (pp >= cfg.pp_min) && (pp <= cfg.pp_max);
    dir_ok     = ((enc_dir == DIR_POS) || (enc_dir == DIR_NEG)) &&
                 ((loop_dir == DIR_POS) || (loop_dir == DIR_NEG));

    res.record_ok     = magic_ok && version_ok && crc_ok && pp_ok && dir_ok;
    res.pair_count    = pp[7:0];
    res.encoder_sense = enc_dir[7:0];
    res.loop_sense    = loop_dir[7:0];
    res.offset_bits   = held[2];
    res.node_number   = ((nid >= cfg.nid_min) && (nid <= cfg.nid_max)) ? nid : 8'd0;
    res.gains_valid   = gains & held[3][8];
    res.velocity_kp   = gains ? held[4][15:0]  : 16'd0;
    res.velocity_ki   = gains ? held[4][31:16] : 16'd0;
    res.position_kp   = gains ? held[5][15:0]  : 16'd0;
    res.position_ki   = gains ? held[5][31:16] : 16'd0;
    res.position_kd   = gains ? held[3][31:16] : 16'd0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/calrec_checker.sv =====
// Port-level assertions for calibration_record_checker, with the bind that attaches them.
// Depends on calrec_pkg and calibration_record_checker_defines.svh.
`default_nettype none

`include "calibration_record_checker_defines.svh"

module calrec_checker
  import calrec_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // a stalled result word stays put
  `CALREC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `CALREC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  // input only backs up once a result is parked behind a waiting output word
  `CALREC_ASSERT_NOW(a_stall_has_result, clk, rst_n, !in_tready, out_tvalid)
  // every new result comes from a word accepted on the previous edge
  `CALREC_ASSERT_NOW(a_result_from_input, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready))

endmodule

bind calibration_record_checker calrec_checker u_calrec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
